// ===== hw/rtl/rmq_pkg.sv =====
// shared types, constants and helper functions of the rotation matrix to quaternion converter
package rmq_pkg;

	localparam int Q_W       = 32;  // width of every rotation, translation and quaternion word
	localparam int IN_N      = 12;  // words in one input beat
	localparam int OUT_N     = 4;   // quaternion words in one output beat
	localparam int RAD_W     = 62;  // radicand, remainder and shifted-root width
	localparam int ROOT_W    = 31;  // bits of every root
	localparam int MAG_W     = 33;  // magnitude of an off-diagonal sum
	localparam int QB_W      = 32;  // quotient bits kept by the divider chain
	localparam int WRK_W     = 36;  // signed working width of the front-end sums
	localparam int NR        = 5;   // roots taken side by side
	localparam int HALF_SH   = 28;  // half root: radicand is a * 2^28
	localparam int PIV_SH    = 29;  // pivot root: radicand is a * 2^29
	localparam int DIV_SH    = 28;  // s / (4p) is s * 2^28 / p
	localparam int OVF_SH    = 4;   // quotient reaches 2^32 when mag >= 16 p
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 2;

	// root lanes
	localparam int LW = 0;
	localparam int LX = 1;
	localparam int LY = 2;
	localparam int LZ = 3;
	localparam int LP = 4;

	// trace-branch word slots, same order as the output beat
	localparam int QX = 0;
	localparam int QY = 1;
	localparam int QZ = 2;
	localparam int QW = 3;

	localparam logic [CFG_W-1:0] ZERO_THR_RST = 31'd16;
	localparam logic [CFG_W-1:0] POS_TOL_RST  = 31'd66;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_THR = 2'd0,
		REG_POS_TOL  = 2'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		PIV_X = 2'd0,
		PIV_Y = 2'd1,
		PIV_Z = 2'd2
	} piv_t;

	typedef struct packed {
		logic             neg_x;
		logic             neg_y;
		logic             neg_z;
		piv_t             piv;
		logic [MAG_W-1:0] mag_a;
		logic [MAG_W-1:0] mag_b;
		logic             neg_a;
		logic             neg_b;
		logic             imprecise;
	} side_t;

	typedef struct packed {
		logic [NR-1:0][RAD_W-1:0] rem;
		logic [NR-1:0][RAD_W-1:0] res;
		side_t                    side;
	} sq_t;

	typedef struct packed {
		logic [RAD_W-1:0]            rem_a;
		logic [RAD_W-1:0]            rem_b;
		logic [QB_W-1:0]             q_a;
		logic [QB_W-1:0]             q_b;
		logic                        ovf_a;
		logic                        ovf_b;
		logic [ROOT_W-1:0]           p;
		logic [OUT_N-1:0][Q_W-1:0]   tq;
		logic                        use_trace;
		piv_t                        piv;
		logic                        neg_a;
		logic                        neg_b;
		logic                        imprecise;
	} dv_t;

	// apply sign and saturate an unsigned quotient to the signed output range
	function automatic logic [Q_W-1:0] sat_quot(input logic [QB_W-1:0] q, input logic ovf,
			input logic neg);
		logic [Q_W-1:0] r;
		if (!neg) begin
			if (ovf || q[QB_W-1]) r = {1'b0, {(Q_W-1){1'b1}}};
			else r = q;
		end else begin
			if (ovf || (q > {1'b1, {(QB_W-1){1'b0}}})) r = {1'b1, {(Q_W-1){1'b0}}};
			else r = -q;
		end
		return r;
	endfunction

	// signed output word from a root magnitude
	function automatic logic [Q_W-1:0] signed_root(input logic [ROOT_W-1:0] h, input logic neg);
		logic [Q_W-1:0] m;
		m = Q_W'(h);
		return neg ? -m : m;
	endfunction

endpackage

// ===== hw/rtl/rmq_prep.sv =====
// front end: trace, root radicands, signs, pivot choice and translation check
module rmq_prep (
	input  logic [rmq_pkg::IN_N*rmq_pkg::Q_W-1:0] in_data,
	input  logic [rmq_pkg::CFG_W-1:0]             pos_tol,
	output rmq_pkg::sq_t                          out
);

	localparam logic signed [rmq_pkg::WRK_W-1:0] ONE = 36'sd1073741824;

	logic signed [rmq_pkg::Q_W-1:0]   r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [rmq_pkg::Q_W-1:0]   tx, ty, tz;
	logic signed [rmq_pkg::WRK_W-1:0] tr, aw, ax, ay, az, e0, e1, e2, f0, f1, f2;
	logic signed [rmq_pkg::WRK_W-1:0] s01, s02, s12, sa, sb, ep, ma, mb;
	logic signed [rmq_pkg::WRK_W-1:0] dx, dy, dz;
	rmq_pkg::piv_t                    piv;

	function automatic logic [rmq_pkg::RAD_W-1:0] rad(input logic signed [rmq_pkg::WRK_W-1:0] a,
			input logic pivot);
		logic [rmq_pkg::RAD_W-1:0] r;
		if (a[rmq_pkg::WRK_W-1]) r = '0;
		else if (pivot) r = rmq_pkg::RAD_W'({a[32:0], {rmq_pkg::PIV_SH{1'b0}}});
		else r = rmq_pkg::RAD_W'({a[32:0], {rmq_pkg::HALF_SH{1'b0}}});
		return r;
	endfunction

	function automatic logic signed [rmq_pkg::WRK_W-1:0] abs_w(
			input logic signed [rmq_pkg::WRK_W-1:0] v);
		return v[rmq_pkg::WRK_W-1] ? -v : v;
	endfunction

	function automatic logic [rmq_pkg::Q_W-1:0] abs_t(input logic signed [rmq_pkg::Q_W-1:0] v);
		return v[rmq_pkg::Q_W-1] ? -v : v;
	endfunction

	assign r00 = signed'(in_data[0*rmq_pkg::Q_W +: rmq_pkg::Q_W]);
	assign r01 = signed'(in_data[1*rmq_pkg::Q_W +: rmq_pkg::Q_W]);
	assign r02 = signed'(in_data[2*rmq_pkg::Q_W +: rmq_pkg::Q_W]);
	assign r10 = signed'(in_data[3*rmq_pkg::Q_W +: rmq_pkg::Q_W]);
	assign r11 = signed'(in_data[4*rmq_pkg::Q_W +: rmq_pkg::Q_W]);
	assign r12 = signed'(in_data[5*rmq_pkg::Q_W +: rmq_pkg::Q_W]);
	assign r20 = signed'(in_data[6*rmq_pkg::Q_W +: rmq_pkg::Q_W]);
	assign r21 = signed'(in_data[7*rmq_pkg::Q_W +: rmq_pkg::Q_W]);
	assign r22 = signed'(in_data[8*rmq_pkg::Q_W +: rmq_pkg::Q_W]);
	assign tx  = signed'(in_data[9*rmq_pkg::Q_W +: rmq_pkg::Q_W]);
	assign ty  = signed'(in_data[10*rmq_pkg::Q_W +: rmq_pkg::Q_W]);
	assign tz  = signed'(in_data[11*rmq_pkg::Q_W +: rmq_pkg::Q_W]);

	always_comb begin
		tr = 36'(r00) + 36'(r11) + 36'(r22);
		aw = tr + ONE;
		ax = ONE + 36'(r00) + 36'(r00) - tr;
		ay = ONE + 36'(r11) + 36'(r11) - tr;
		az = ONE + 36'(r22) + 36'(r22) - tr;
		e0 = 36'(r00) + ONE;
		e1 = 36'(r11) + ONE;
		e2 = 36'(r22) + ONE;
		f0 = abs_w(e0);
		f1 = abs_w(e1);
		f2 = abs_w(e2);
		s01 = 36'(r01) + 36'(r10);
		s02 = 36'(r02) + 36'(r20);
		s12 = 36'(r12) + 36'(r21);
		dx = 36'(r21) - 36'(r12);
		dy = 36'(r02) - 36'(r20);
		dz = 36'(r10) - 36'(r01);

		// ties go to x, then y
		if (f0 >= f1 && f0 >= f2) piv = rmq_pkg::PIV_X;
		else if (f1 >= f2) piv = rmq_pkg::PIV_Y;
		else piv = rmq_pkg::PIV_Z;

		case (piv)
			rmq_pkg::PIV_X: begin
				ep = e0; sa = s01; sb = s02;
			end
			rmq_pkg::PIV_Y: begin
				ep = e1; sa = s01; sb = s12;
			end
			rmq_pkg::PIV_Z: begin
				ep = e2; sa = s02; sb = s12;
			end
			default: begin
				ep = e0; sa = s01; sb = s02;
			end
		endcase

		ma = abs_w(sa);
		mb = abs_w(sb);

		out.rem[rmq_pkg::LW] = rad(aw, 1'b0);
		out.rem[rmq_pkg::LX] = rad(ax, 1'b0);
		out.rem[rmq_pkg::LY] = rad(ay, 1'b0);
		out.rem[rmq_pkg::LZ] = rad(az, 1'b0);
		out.rem[rmq_pkg::LP] = rad(ep, 1'b1);
		out.res = '0;
		out.side.neg_x = dx[rmq_pkg::WRK_W-1];
		out.side.neg_y = dy[rmq_pkg::WRK_W-1];
		out.side.neg_z = dz[rmq_pkg::WRK_W-1];
		out.side.piv   = piv;
		out.side.mag_a = ma[rmq_pkg::MAG_W-1:0];
		out.side.mag_b = mb[rmq_pkg::MAG_W-1:0];
		out.side.neg_a = sa[rmq_pkg::WRK_W-1];
		out.side.neg_b = sb[rmq_pkg::WRK_W-1];
		out.side.imprecise = (abs_t(tx) > {1'b0, pos_tol}) || (abs_t(ty) > {1'b0, pos_tol})
			|| (abs_t(tz) > {1'b0, pos_tol});
	end

endmodule

// ===== hw/rtl/rmq_sqrt_cell.sv =====
// one digit step of five square roots taken side by side
module rmq_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  rmq_pkg::sq_t in,
	output logic         out_valid,
	output rmq_pkg::sq_t out
);

	localparam logic [rmq_pkg::RAD_W-1:0] BIT = rmq_pkg::RAD_W'(1) << (2 * STEP);

	rmq_pkg::sq_t nxt;
	logic         valid_q;
	rmq_pkg::sq_t data_q;

	always_comb begin
		logic [rmq_pkg::RAD_W-1:0] t;
		nxt = in;
		for (int n = 0; n < rmq_pkg::NR; n++) begin
			t = in.res[n] + BIT;
			if (in.rem[n] >= t) begin
				nxt.rem[n] = in.rem[n] - t;
				nxt.res[n] = (in.res[n] >> 1) + BIT;
			end else begin
				nxt.res[n] = in.res[n] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (en) valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out       = data_q;

endmodule

// ===== hw/rtl/rmq_div_cell.sv =====
// one quotient bit of the two fallback divisions
module rmq_div_cell #(
	parameter int STEP = 0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  rmq_pkg::dv_t in,
	output logic         out_valid,
	output rmq_pkg::dv_t out
);

	rmq_pkg::dv_t nxt;
	logic         valid_q;
	rmq_pkg::dv_t data_q;

	always_comb begin
		logic [rmq_pkg::RAD_W-1:0] d;
		d   = rmq_pkg::RAD_W'(in.p) << STEP;
		nxt = in;
		if (in.rem_a >= d) begin
			nxt.rem_a     = in.rem_a - d;
			nxt.q_a[STEP] = 1'b1;
		end
		if (in.rem_b >= d) begin
			nxt.rem_b     = in.rem_b - d;
			nxt.q_b[STEP] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (en) valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out       = data_q;

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion_top.sv =====
// top level: rotation matrix to unit quaternion converter with translation check
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-------------------------------------------------
//  s_*     | in        | s_tvalid/s_tready| s_tdata: r00 r01 r02 r10 r11 r12 r20 r21 r22
//          |           |                  |          trans_x trans_y trans_z (32 bit each)
//  m_*     | out       | m_tvalid/m_tready| m_tdata: quat_x quat_y quat_z quat_w; m_tuser: imprecise
//  cfg_*   | in        | cfg_valid/ready  | cfg_index, cfg_data (zero_threshold, position_tolerance)
//
// one beat per cycle in and out while the output is not held; stages: input register, 31 root cells,
// a branch stage, 32 divider cells and the output register
// the root chain (one root bit per cell) and the divider chain (one quotient bit per cell)
// set the latency; every cell takes new data each cycle
// when the output beat is held the whole chain stalls together; s_tready follows that
// reset clears the valid bits of every stage and loads the register reset values
// cfg_ready is always high; writes to unknown indexes are dropped
module rotation_matrix_to_quaternion_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22, trans_x, trans_y, trans_z from bit 0
	input  logic [rmq_pkg::IN_N*rmq_pkg::Q_W-1:0]    s_tdata,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// quat_x, quat_y, quat_z, quat_w from bit 0
	output logic [rmq_pkg::OUT_N*rmq_pkg::Q_W-1:0]   m_tdata,
	// imprecise
	output logic [0:0]                               m_tuser,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [rmq_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [rmq_pkg::Q_W-1:0]                  cfg_data
);

	logic [rmq_pkg::CFG_W-1:0] zero_thr_q, pos_tol_q;
	logic                      en;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_thr_q <= rmq_pkg::ZERO_THR_RST;
			pos_tol_q  <= rmq_pkg::POS_TOL_RST;
		end else if (cfg_valid) begin
			case (rmq_pkg::reg_idx_t'(cfg_index))
				rmq_pkg::REG_ZERO_THR: zero_thr_q <= cfg_data[rmq_pkg::CFG_W-1:0];
				rmq_pkg::REG_POS_TOL:  pos_tol_q  <= cfg_data[rmq_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// global advance: the output slot is free or being emptied
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// input stage
	rmq_pkg::sq_t prep_d, sq_s1;
	logic         valid_s1;

	rmq_prep u_prep (
		.in_data (s_tdata),
		.pos_tol (pos_tol_q),
		.out     (prep_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) sq_s1 <= prep_d;
	end

	// root chain, most significant root bit first
	rmq_pkg::sq_t sq_c [rmq_pkg::ROOT_W+1];
	logic         sv_c [rmq_pkg::ROOT_W+1];

	assign sq_c[0] = sq_s1;
	assign sv_c[0] = valid_s1;

	for (genvar k = 0; k < rmq_pkg::ROOT_W; k++) begin : g_sqrt
		rmq_sqrt_cell #(.STEP(rmq_pkg::ROOT_W - 1 - k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sv_c[k]),
			.in        (sq_c[k]),
			.out_valid (sv_c[k+1]),
			.out       (sq_c[k+1])
		);
	end

	// branch stage: trace-branch words, branch choice, divider setup
	rmq_pkg::sq_t              sq_end;
	rmq_pkg::dv_t              mid_d, dv_s2;
	logic                      valid_s2;
	logic [rmq_pkg::ROOT_W-1:0] tw, pv;

	assign sq_end = sq_c[rmq_pkg::ROOT_W];
	assign tw     = sq_end.res[rmq_pkg::LW][rmq_pkg::ROOT_W-1:0];
	assign pv     = sq_end.res[rmq_pkg::LP][rmq_pkg::ROOT_W-1:0];

	always_comb begin
		mid_d = '0;
		mid_d.tq[rmq_pkg::QX] = rmq_pkg::signed_root(
			sq_end.res[rmq_pkg::LX][rmq_pkg::ROOT_W-1:0], sq_end.side.neg_x);
		mid_d.tq[rmq_pkg::QY] = rmq_pkg::signed_root(
			sq_end.res[rmq_pkg::LY][rmq_pkg::ROOT_W-1:0], sq_end.side.neg_y);
		mid_d.tq[rmq_pkg::QZ] = rmq_pkg::signed_root(
			sq_end.res[rmq_pkg::LZ][rmq_pkg::ROOT_W-1:0], sq_end.side.neg_z);
		mid_d.tq[rmq_pkg::QW] = rmq_pkg::Q_W'(tw);
		mid_d.use_trace = tw > zero_thr_q;
		mid_d.p         = pv;
		mid_d.rem_a = rmq_pkg::RAD_W'({sq_end.side.mag_a, {rmq_pkg::DIV_SH{1'b0}}});
		mid_d.rem_b = rmq_pkg::RAD_W'({sq_end.side.mag_b, {rmq_pkg::DIV_SH{1'b0}}});
		// quotient would need more than the kept bits
		mid_d.ovf_a = {2'b00, sq_end.side.mag_a} >= {pv, {rmq_pkg::OVF_SH{1'b0}}};
		mid_d.ovf_b = {2'b00, sq_end.side.mag_b} >= {pv, {rmq_pkg::OVF_SH{1'b0}}};
		mid_d.piv       = sq_end.side.piv;
		mid_d.neg_a     = sq_end.side.neg_a;
		mid_d.neg_b     = sq_end.side.neg_b;
		mid_d.imprecise = sq_end.side.imprecise;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= sv_c[rmq_pkg::ROOT_W];
	end

	always_ff @(posedge clk) begin
		if (en) dv_s2 <= mid_d;
	end

	// divider chain, most significant quotient bit first
	rmq_pkg::dv_t dv_c [rmq_pkg::QB_W+1];
	logic         dvv_c [rmq_pkg::QB_W+1];

	assign dv_c[0]  = dv_s2;
	assign dvv_c[0] = valid_s2;

	for (genvar k = 0; k < rmq_pkg::QB_W; k++) begin : g_div
		rmq_div_cell #(.STEP(rmq_pkg::QB_W - 1 - k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dvv_c[k]),
			.in        (dv_c[k]),
			.out_valid (dvv_c[k+1]),
			.out       (dv_c[k+1])
		);
	end

	// output stage
	rmq_pkg::dv_t                            dv_end;
	logic [rmq_pkg::Q_W-1:0]                 qa, qb, qp;
	logic [rmq_pkg::OUT_N-1:0][rmq_pkg::Q_W-1:0] quat_d, out_data_q;
	logic                                    out_valid_q, out_user_q;

	assign dv_end = dv_c[rmq_pkg::QB_W];

	always_comb begin
		qp = rmq_pkg::Q_W'(dv_end.p);
		// zero pivot root gives zero derived parts
		if (dv_end.p == '0) begin
			qa = '0;
			qb = '0;
		end else begin
			qa = rmq_pkg::sat_quot(dv_end.q_a, dv_end.ovf_a, dv_end.neg_a);
			qb = rmq_pkg::sat_quot(dv_end.q_b, dv_end.ovf_b, dv_end.neg_b);
		end
		quat_d[rmq_pkg::QW] = dv_end.tq[rmq_pkg::QW];
		if (dv_end.use_trace) begin
			quat_d[rmq_pkg::QX] = dv_end.tq[rmq_pkg::QX];
			quat_d[rmq_pkg::QY] = dv_end.tq[rmq_pkg::QY];
			quat_d[rmq_pkg::QZ] = dv_end.tq[rmq_pkg::QZ];
		end else begin
			case (dv_end.piv)
				rmq_pkg::PIV_X: begin
					quat_d[rmq_pkg::QX] = qp;
					quat_d[rmq_pkg::QY] = qa;
					quat_d[rmq_pkg::QZ] = qb;
				end
				rmq_pkg::PIV_Y: begin
					quat_d[rmq_pkg::QX] = qa;
					quat_d[rmq_pkg::QY] = qp;
					quat_d[rmq_pkg::QZ] = qb;
				end
				rmq_pkg::PIV_Z: begin
					quat_d[rmq_pkg::QX] = qa;
					quat_d[rmq_pkg::QY] = qb;
					quat_d[rmq_pkg::QZ] = qp;
				end
				default: begin
					quat_d[rmq_pkg::QX] = qp;
					quat_d[rmq_pkg::QY] = qa;
					quat_d[rmq_pkg::QZ] = qb;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= dvv_c[rmq_pkg::QB_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= quat_d;
			out_user_q <= dv_end.imprecise;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_user_q;

	// scalar part is a root and never negative
	a_w_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[rmq_pkg::OUT_N*rmq_pkg::Q_W-1])
		else $error("quat_w negative");

	// roots fit their width at the end of the chain
	a_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		sv_c[rmq_pkg::ROOT_W] |->
			(sq_end.res[rmq_pkg::LW][rmq_pkg::RAD_W-1:rmq_pkg::ROOT_W] == '0) &&
			(sq_end.res[rmq_pkg::LP][rmq_pkg::RAD_W-1:rmq_pkg::ROOT_W] == '0))
		else $error("root wider than expected");

	// a stall freezes the chains
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s2) && $stable(dvv_c[rmq_pkg::QB_W]) && $stable(valid_s1))
		else $error("pipeline moved during stall");

endmodule

// ===== tb/rotation_matrix_to_quaternion_top_tb.sv =====
// testbench for the rotation matrix to quaternion converter: directed rows, then random matrices
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_top_tb;
	import rmq_pkg::*;

	localparam logic [Q_W-1:0] Q1    = 32'h4000_0000;  // +1.0 in Q2.30
	localparam logic [Q_W-1:0] QM1   = 32'hC000_0000;  // -1.0 in Q2.30
	localparam logic [Q_W-1:0] QH    = 32'h2000_0000;  // +0.5 in Q2.30
	localparam logic [Q_W-1:0] WMAX  = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] WMIN  = 32'h8000_0000;
	localparam logic [CFG_IDX_W-1:0] BAD_IDX = 2'd3;  // no register lives here
	localparam int SETTLE = 80;                        // longer than the pipeline latency

	typedef struct {
		logic [Q_W-1:0] qx, qy, qz, qw;
		logic           imp;
	} quat_beat_t;

	typedef struct {
		logic [IN_N*Q_W-1:0] words;
		bit                  typed;  // expected beat written in by hand
		quat_beat_t          want;
	} stim_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_N*Q_W-1:0]     s_tdata;   // r00 r01 r02 r10 r11 r12 r20 r21 r22 tx ty tz from bit 0
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_N*Q_W-1:0]    m_tdata;   // quat_x quat_y quat_z quat_w from bit 0
	logic [0:0]              m_tuser;   // imprecise
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [Q_W-1:0]          cfg_data;

	// shadow copy of the two registers
	longint unsigned thr_shadow;
	longint unsigned tol_shadow;

	quat_beat_t pending_quats[$];
	stim_row_t  directed_rows[$];
	int         mismatches = 0;
	int         burst_left = 0;
	int         cyc = 0;

	rotation_matrix_to_quaternion_top uut (.*);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned res = 0;
		longint unsigned b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// 0.5*sqrt(a), zero for a negative argument
	function automatic longint half_sqrt(input longint a);
		if (a < 0) return 0;
		return longint'(int_sqrt(longint'(a) << HALF_SH));
	endfunction

	// sqrt(0.5*(d+1))
	function automatic longint pivot_sqrt(input longint d);
		longint a;
		a = d + longint'(Q1);
		if (a < 0) return 0;
		return longint'(int_sqrt(a << PIV_SH));
	endfunction

	// s / (4p), zero when p is zero
	function automatic longint quarter_quot(input longint s, input longint p);
		longint unsigned mag, q;
		if (p <= 0) return 0;
		mag = s < 0 ? longint'(-s) : s;
		q = (mag << DIV_SH) / p;
		if (q > (64'd1 << 40)) q = 64'd1 << 40;
		return s < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [Q_W-1:0] clip32(input longint v);
		if (v > 64'sh7FFF_FFFF) return WMAX;
		if (v < -64'sh8000_0000) return WMIN;
		return v[Q_W-1:0];
	endfunction

	function automatic longint mag64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic quat_beat_t predict_quat(input logic [IN_N*Q_W-1:0] w);
		longint r[IN_N];
		longint tr, qx, qy, qz, qw, f0, f1, f2;
		quat_beat_t o;
		for (int i = 0; i < IN_N; i++) r[i] = longint'(signed'(w[i*Q_W +: Q_W]));
		// r[0..8] = r00 r01 r02 r10 r11 r12 r20 r21 r22
		tr = r[0] + r[4] + r[8];
		qw = half_sqrt(tr + longint'(Q1));
		if (qw > longint'(thr_shadow)) begin
			qx = half_sqrt(longint'(Q1) + 2 * r[0] - tr);
			qy = half_sqrt(longint'(Q1) + 2 * r[4] - tr);
			qz = half_sqrt(longint'(Q1) + 2 * r[8] - tr);
			// zero difference keeps the positive sign
			if (r[7] - r[5] < 0) qx = -qx;
			if (r[2] - r[6] < 0) qy = -qy;
			if (r[3] - r[1] < 0) qz = -qz;
		end else begin
			f0 = mag64(r[0] + longint'(Q1));
			f1 = mag64(r[4] + longint'(Q1));
			f2 = mag64(r[8] + longint'(Q1));
			// ties go to x, then y
			if (f0 >= f1 && f0 >= f2) begin
				qx = pivot_sqrt(r[0]);
				qy = quarter_quot(r[1] + r[3], qx);
				qz = quarter_quot(r[2] + r[6], qx);
			end else if (f1 >= f2) begin
				qy = pivot_sqrt(r[4]);
				qx = quarter_quot(r[3] + r[1], qy);
				qz = quarter_quot(r[5] + r[7], qy);
			end else begin
				qz = pivot_sqrt(r[8]);
				qx = quarter_quot(r[6] + r[2], qz);
				qy = quarter_quot(r[7] + r[5], qz);
			end
		end
		o.imp = 1'b0;
		for (int i = 9; i < IN_N; i++)
			if (mag64(r[i]) > longint'(tol_shadow)) o.imp = 1'b1;
		o.qx = clip32(qx);
		o.qy = clip32(qy);
		o.qz = clip32(qz);
		o.qw = clip32(qw);
		return o;
	endfunction

	// ---------------------------------------------------------------- helpers

	function automatic logic [IN_N*Q_W-1:0] pack_xform(
			input logic [Q_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
			input logic [Q_W-1:0] tx, ty, tz);
		return {tz, ty, tx, a22, a21, a20, a12, a11, a10, a02, a01, a00};
	endfunction

	function automatic quat_beat_t mk_quat(input logic [Q_W-1:0] x, y, z, w, input logic imp);
		quat_beat_t o;
		o.qx = x; o.qy = y; o.qz = z; o.qw = w; o.imp = imp;
		return o;
	endfunction

	task automatic add_row(input logic [IN_N*Q_W-1:0] w, input bit typed, input quat_beat_t q);
		stim_row_t row;
		row.words = w;
		row.typed = typed;
		row.want  = q;
		directed_rows.push_back(row);
	endtask

	task automatic report(input string what, input logic [Q_W-1:0] got, input logic [Q_W-1:0] want);
		mismatches++;
		if (mismatches <= 30)
			$display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
	endtask

	// one beat into the converter; bursts and gaps shape the sender side
	task automatic send_xform(input logic [IN_N*Q_W-1:0] w, input bit typed, input quat_beat_t q);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		pending_quats.push_back(typed ? q : predict_quat(w));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// pause the sender until the pipe has drained
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_quats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one write beat, then the channel goes idle before the task returns
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ZERO_THR) thr_shadow = val & 32'h7FFF_FFFF;
		else if (idx == REG_POS_TOL) tol_shadow = val & 32'h7FFF_FFFF;
		@(posedge clk);
	endtask

	function automatic logic [Q_W-1:0] rand_entry(input int mode);
		logic [Q_W-1:0] v;
		case (mode)
			0: begin
				v = $urandom();
			end
			1: begin
				// near a signed unit on the diagonal of a permuted frame
				v = ($urandom_range(0, 1) ? Q1 : QM1) + $urandom_range(0, 64) - 32;
			end
			2: begin
				v = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
			end
			default: begin
				v = $urandom_range(0, 1024) - 512;
			end
		endcase
		return v;
	endfunction

	function automatic logic [IN_N*Q_W-1:0] rand_xform();
		logic [Q_W-1:0] e[IN_N];
		int mode, perm;
		mode = $urandom_range(0, 9);
		if (mode < 5) begin
			// signed permutation matrix with small noise: hits every branch and pivot
			perm = $urandom_range(0, 5);
			for (int i = 0; i < 9; i++) e[i] = rand_entry(3);
			for (int row = 0; row < 3; row++) begin
				int col;
				col = (perm < 3) ? (row + perm) % 3 : (perm - row + 3) % 3;
				e[row * 3 + col] = rand_entry(1);
			end
		end else begin
			for (int i = 0; i < 9; i++) e[i] = rand_entry(mode < 8 ? 2 : 0);
		end
		for (int i = 9; i < IN_N; i++) begin
			if ($urandom_range(0, 3) == 0) e[i] = $urandom();
			else e[i] = Q_W'(longint'(tol_shadow) + $urandom_range(0, 8) - 4
				- ($urandom_range(0, 1) ? 2 * longint'(tol_shadow) : 0));
		end
		return pack_xform(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8],
			e[9], e[10], e[11]);
	endfunction

	// ---------------------------------------------------------------- receiver

	// stalls: free-running stretches, a fixed comb, and coin flips
	always @(posedge clk) begin
		cyc <= cyc + 1;
		case (cyc[10:9])
			2'd0:    m_tready <= 1'b1;
			2'd1:    m_tready <= (cyc % 7) != 3;
			default: m_tready <= $urandom_range(0, 3) != 0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_quats.size() == 0) begin
				report("unexpected beat", m_tdata[Q_W-1:0], '0);
			end else begin
				quat_beat_t w;
				w = pending_quats.pop_front();
				if (m_tdata[QX*Q_W +: Q_W] !== w.qx) report("quat_x", m_tdata[QX*Q_W +: Q_W], w.qx);
				if (m_tdata[QY*Q_W +: Q_W] !== w.qy) report("quat_y", m_tdata[QY*Q_W +: Q_W], w.qy);
				if (m_tdata[QZ*Q_W +: Q_W] !== w.qz) report("quat_z", m_tdata[QZ*Q_W +: Q_W], w.qz);
				if (m_tdata[QW*Q_W +: Q_W] !== w.qw) report("quat_w", m_tdata[QW*Q_W +: Q_W], w.qw);
				if (m_tuser[0] !== w.imp)
					report("imprecise", Q_W'(m_tuser[0]), Q_W'(w.imp));
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	initial begin
		quat_beat_t none;
		none = mk_quat('0, '0, '0, '0, 1'b0);
		arst_n    = 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ZERO_THR;
		cfg_data  <= '0;
		thr_shadow = ZERO_THR_RST;
		tol_shadow = POS_TOL_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, zero matrix and the three half turns
		add_row(pack_xform(Q1, 0, 0, 0, Q1, 0, 0, 0, Q1, 0, 0, 0), 1, mk_quat(0, 0, 0, Q1, 0));
		add_row(pack_xform(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_quat(QH, QH, QH, QH, 0));
		add_row(pack_xform(Q1, 0, 0, 0, QM1, 0, 0, 0, QM1, 0, 0, 0), 1, mk_quat(Q1, 0, 0, 0, 0));
		add_row(pack_xform(QM1, 0, 0, 0, Q1, 0, 0, 0, QM1, 0, 0, 0), 1, mk_quat(0, Q1, 0, 0, 0));
		add_row(pack_xform(QM1, 0, 0, 0, QM1, 0, 0, 0, Q1, 0, 0, 0), 1, mk_quat(0, 0, Q1, 0, 0));
		// pivot root of zero: divisor is zero so everything is zero
		add_row(pack_xform(QM1, 0, 0, 0, QM1, 0, 0, 0, QM1, 0, 0, 0), 1, none);
		// translation right at and just past the tolerance, and the most negative word
		add_row(pack_xform(Q1, 0, 0, 0, Q1, 0, 0, 0, Q1, 66, -66, 66), 1, mk_quat(0, 0, 0, Q1, 0));
		add_row(pack_xform(Q1, 0, 0, 0, Q1, 0, 0, 0, Q1, 67, 0, 0), 1, mk_quat(0, 0, 0, Q1, 1));
		add_row(pack_xform(Q1, 0, 0, 0, Q1, 0, 0, 0, Q1, 0, -67, 0), 1, mk_quat(0, 0, 0, Q1, 1));
		add_row(pack_xform(Q1, 0, 0, 0, Q1, 0, 0, 0, Q1, 0, 0, WMIN), 1, mk_quat(0, 0, 0, Q1, 1));
		// extremes of every field
		add_row(pack_xform(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX,
			WMAX, WMAX, WMAX), 0, none);
		add_row(pack_xform(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN,
			WMIN, WMIN, WMIN), 0, none);
		add_row(pack_xform(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555), 0, none);
		// tiny pivot with large off-diagonal sums: quotient saturates both ways
		add_row(pack_xform(QM1 + 4, WMAX, WMIN, WMAX, QM1, 0, WMIN, 0, QM1, 0, 0, 0), 0, none);
		// tie between x and y pivots
		add_row(pack_xform(0, 5, 7, 9, 0, 11, 13, 15, QM1, 0, 0, 0), 0, none);
		// quarter turns about z, both senses, and a negative root argument
		add_row(pack_xform(0, QM1, 0, Q1, 0, 0, 0, 0, Q1, 0, 0, 0), 0, none);
		add_row(pack_xform(0, Q1, 0, QM1, 0, 0, 0, 0, Q1, 0, 0, 0), 0, none);
		add_row(pack_xform(Q1, 0, 0, 0, Q1, 0, 0, 0, QM1, 0, 0, 0), 0, none);
		add_row(pack_xform(0, 0, Q1, 0, Q1, 0, QM1, 0, 0, 1, 2, 3), 0, none);

		foreach (directed_rows[i])
			send_xform(directed_rows[i].words, directed_rows[i].typed, directed_rows[i].want);

		// register settings per phase: extremes first, then random ones
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(REG_ZERO_THR, 0);
					write_reg(REG_POS_TOL, 0);
				end
				1: begin
					write_reg(REG_ZERO_THR, 32'h4000_0000);
					write_reg(REG_POS_TOL, 32'h7FFF_FFFF);
				end
				2: begin
					write_reg(BAD_IDX, 32'h1234_5678);  // dropped
					write_reg(REG_ZERO_THR, $urandom_range(0, 32'h2000_0000));
					write_reg(REG_POS_TOL, $urandom_range(0, 32'h0010_0000));
				end
				3: begin
					write_reg(REG_ZERO_THR, ZERO_THR_RST);
					write_reg(REG_POS_TOL, $urandom_range(0, 32'h7FFF_FFFF));
				end
				default: begin
					write_reg(REG_ZERO_THR, $urandom_range(0, 32'h4000_0000));
					write_reg(REG_POS_TOL, POS_TOL_RST);
				end
			endcase
			repeat (380) send_xform(rand_xform(), 0, none);
		end

		s_tvalid <= 1'b0;
		while (pending_quats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// hard stop if the pipe hangs
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_prep.sv
hw/rtl/rmq_sqrt_cell.sv
hw/rtl/rmq_div_cell.sv
hw/rtl/rotation_matrix_to_quaternion_top.sv
tb/rotation_matrix_to_quaternion_top_tb.sv
